// File: hdl/assert_macros.svh
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Check an implication on every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
// Check that the consequence holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`endif

// File: hdl/aapr_pkg.sv
// Shared constants, types and helpers of the axis-angle rotation unit.
package aapr_pkg;
    localparam int CordicSteps = 18;
    localparam int NumLanes = 3;
    localparam int SqrtSteps = 32;
    localparam int DivSteps = 32;
    localparam logic signed [34:0] Q30One = 35'sd1073741824;
    localparam logic signed [34:0] Q30Pi = 35'sd3373259426;
    localparam logic signed [34:0] Q30HalfPi = 35'sd1686629713;
    localparam logic signed [34:0] CordicGain = 35'sd652032874;
    localparam logic [65:0] LenSqZeroLimit = 66'd4294;

    typedef logic signed [34:0] q30_t;

    // Arctangent table in Q2.30.
    function automatic logic [31:0] atan_q30(input logic [4:0] idx);
        logic [31:0] r;
        case (idx)
            5'd0: r = 32'h3243F6A8; 5'd1: r = 32'h1DAC6705; 5'd2: r = 32'h0FADBAFC;
            5'd3: r = 32'h07F56EA6; 5'd4: r = 32'h03FEAB76; 5'd5: r = 32'h01FFD55B;
            5'd6: r = 32'h00FFFAAA; 5'd7: r = 32'h007FFF55; 5'd8: r = 32'h003FFFEA;
            5'd9: r = 32'h001FFFFD; 5'd10: r = 32'h000FFFFF; 5'd11: r = 32'h0007FFFF;
            5'd12: r = 32'h0003FFFF; 5'd13: r = 32'h0001FFFF; 5'd14: r = 32'h0000FFFF;
            5'd15: r = 32'h00007FFF; 5'd16: r = 32'h00003FFF; 5'd17: r = 32'h00001FFF;
            5'd18: r = 32'h00000FFF; 5'd19: r = 32'h000007FF; 5'd20: r = 32'h000003FF;
            5'd21: r = 32'h000001FF; 5'd22: r = 32'h000000FF; 5'd23: r = 32'h0000007F;
            5'd24: r = 32'h0000003F; 5'd25: r = 32'h0000001F; 5'd26: r = 32'h0000000F;
            5'd27: r = 32'h00000008; 5'd28: r = 32'h00000004; 5'd29: r = 32'h00000002;
            5'd30: r = 32'h00000001;
            default: r = 32'h00000000;
        endcase
        return r;
    endfunction

    // Product of two Q2.30 values, rounded half up to Q2.30.
    function automatic q30_t mul30(input q30_t a, input q30_t b);
        logic signed [69:0] p;
        p = 70'(a) * 70'(b) + 70'sd536870912;
        return q30_t'(p >>> 30);
    endfunction
endpackage

// File: hdl/axis_angle_point_rotation_unit.sv
// The normalizer spans 68 stages and the rotator 4.
// Throughput: one request per cycle; the whole pipeline advances when the
// output register is free or being taken.
// The axis normalizer (square root and divider lanes, one bit per stage) sets the latency.
// Reset (aresetn low, synchronous) clears valid flags and sets the threshold to 1.
// Top level of the axis-angle point rotation unit.
`include "assert_macros.svh"
module axis_angle_point_rotation_unit (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [16:0]  cfg_data,
    input  logic         s_tvalid,
    output logic         s_tready,
    // tdata: point_x, point_y, point_z, axis_x, axis_y, axis_z, sine_value,
    // cosine_value, angle (lowest first), zero filled to 256 bits
    input  logic [255:0] s_tdata,
    input  logic         s_tuser,   // func
    output logic         m_tvalid,
    input  logic         m_tready,
    // tdata: rotated_x, rotated_y, rotated_z (lowest first)
    output logic [95:0]  m_tdata,
    // tuser: saturated, axis_replaced (lowest first)
    output logic [1:0]   m_tuser
);
    localparam int NormLat = 3 + aapr_pkg::SqrtSteps + 1 + aapr_pkg::DivSteps;
    localparam int Lat = NormLat + 4;
    localparam int CordLat = aapr_pkg::CordicSteps + 1;

    logic [16:0] thresh_reg;
    logic        en;
    logic [Lat-1:0] vld_reg;

    assign cfg_ready = 1'b1;
    assign en = !m_tvalid || m_tready;
    assign s_tready = en;
    assign m_tvalid = vld_reg[Lat-1];

    // Hold the threshold register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thresh_reg <= 17'd1;
        end else if (cfg_valid) begin
            thresh_reg <= cfg_data;
        end
    end

    // Advance the valid line
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[Lat-2:0], s_tvalid};
        end
    end

    // Cordic lane, delayed to meet the normalizer output
    aapr_pkg::q30_t cs, cc;
    aapr_cordic u_cordic (.aclk(aclk), .en(en), .angle(s_tdata[246:228]),
                          .sine(cs), .cosine(cc));

    aapr_pkg::q30_t sc_s_reg [NormLat], sc_c_reg [NormLat];
    logic signed [31:0] pd_reg [NormLat][3];
    logic fn_reg [CordLat];
    aapr_pkg::q30_t sin0, cos0;
    assign sin0 = fn_reg[CordLat-1] ? cs : sc_s_reg[CordLat-1];
    assign cos0 = fn_reg[CordLat-1] ? cc : sc_c_reg[CordLat-1];

    always_ff @(posedge aclk) begin
        if (en) begin
            sc_s_reg[0] <= aapr_pkg::q30_t'($signed(s_tdata[209:192])) <<< 14;
            sc_c_reg[0] <= aapr_pkg::q30_t'($signed(s_tdata[227:210])) <<< 14;
            fn_reg[0] <= s_tuser;
            pd_reg[0][0] <= s_tdata[31:0];
            pd_reg[0][1] <= s_tdata[63:32];
            pd_reg[0][2] <= s_tdata[95:64];
            for (int k = 1; k < NormLat; k++) begin
                pd_reg[k] <= pd_reg[k-1];
                if (k == CordLat) begin
                    sc_s_reg[k] <= sin0;
                    sc_c_reg[k] <= cos0;
                end else begin
                    sc_s_reg[k] <= sc_s_reg[k-1];
                    sc_c_reg[k] <= sc_c_reg[k-1];
                end
            end
            for (int k = 1; k < CordLat; k++) fn_reg[k] <= fn_reg[k-1];
        end
    end

    aapr_pkg::q30_t rx, ry, rz;
    logic repl;
    aapr_norm u_norm (.aclk(aclk), .en(en), .ax(s_tdata[127:96]), .ay(s_tdata[159:128]),
                      .az(s_tdata[191:160]), .thresh(thresh_reg),
                      .rx(rx), .ry(ry), .rz(rz), .replaced(repl));

    logic repl_reg [4];
    always_ff @(posedge aclk) begin
        if (en) begin
            repl_reg[0] <= repl;
            for (int k = 1; k < 4; k++) repl_reg[k] <= repl_reg[k-1];
        end
    end

    logic signed [31:0] qx, qy, qz;
    logic sat;
    aapr_rotate u_rot (.aclk(aclk), .en(en), .rx(rx), .ry(ry), .rz(rz),
                       .s(sc_s_reg[NormLat-1]), .c(sc_c_reg[NormLat-1]),
                       .px(pd_reg[NormLat-1][0]), .py(pd_reg[NormLat-1][1]),
                       .pz(pd_reg[NormLat-1][2]),
                       .qx(qx), .qy(qy), .qz(qz), .sat(sat));

    assign m_tdata = {qz, qy, qx};
    assign m_tuser = {repl_reg[3], sat};

    `ASSERT_NEXT(a_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid,
                 "result dropped while stalled")
    `ASSERT_IMPL(a_ready, aclk, aresetn, !m_tvalid, s_tready,
                 "input stalled with empty output")
    `ASSERT_NEXT(a_cfg, aclk, aresetn, cfg_valid, thresh_reg == $past(cfg_data),
                 "threshold not written")
endmodule

// File: hdl/aapr_cordic.sv
// Pipelined CORDIC rotator: one angle enters per cycle while en is high, sine and cosine leave.
module aapr_cordic (
    input  logic                  aclk,
    input  logic                  en,
    input  logic signed [18:0]    angle,
    output aapr_pkg::q30_t        sine,
    output aapr_pkg::q30_t        cosine
);
    localparam int N = aapr_pkg::CordicSteps;

    aapr_pkg::q30_t x_reg [N+1];
    aapr_pkg::q30_t y_reg [N+1];
    aapr_pkg::q30_t z_reg [N+1];
    logic           neg_reg [N+1];
    aapr_pkg::q30_t z0;
    aapr_pkg::q30_t zf;

    // Fold the angle into the half-pi range
    always_comb begin
        z0 = aapr_pkg::q30_t'(angle) <<< 14;
        if (z0 > aapr_pkg::Q30HalfPi) begin
            zf = z0 - aapr_pkg::Q30Pi;
        end else if (z0 < -aapr_pkg::Q30HalfPi) begin
            zf = z0 + aapr_pkg::Q30Pi;
        end else begin
            zf = z0;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg[0] <= aapr_pkg::CordicGain;
            y_reg[0] <= '0;
            z_reg[0] <= zf;
            neg_reg[0] <= (z0 > aapr_pkg::Q30HalfPi) || (z0 < -aapr_pkg::Q30HalfPi);
        end
    end

    // One rotation step per stage
    for (genvar i = 0; i < N; i++) begin : g_step
        always_ff @(posedge aclk) begin
            if (en) begin
                neg_reg[i+1] <= neg_reg[i];
                if (!z_reg[i][34]) begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - aapr_pkg::q30_t'({1'b0, aapr_pkg::atan_q30(5'(i))});
                end else begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + aapr_pkg::q30_t'({1'b0, aapr_pkg::atan_q30(5'(i))});
                end
            end
        end
    end

    assign sine   = neg_reg[N] ? -y_reg[N] : y_reg[N];
    assign cosine = neg_reg[N] ? -x_reg[N] : x_reg[N];
endmodule

// File: hdl/aapr_norm.sv
// Pipelined axis normalizer: squared length, square root, three divider lanes.
module aapr_norm (
    input  logic               aclk,
    input  logic               en,
    input  logic signed [31:0] ax,
    input  logic signed [31:0] ay,
    input  logic signed [31:0] az,
    input  logic        [16:0] thresh,
    output aapr_pkg::q30_t     rx,
    output aapr_pkg::q30_t     ry,
    output aapr_pkg::q30_t     rz,
    output logic               replaced
);
    localparam int NS = aapr_pkg::SqrtSteps;
    localparam int ND = aapr_pkg::DivSteps;
    localparam int NL = aapr_pkg::NumLanes;

    // Stage 1: squares
    logic [63:0] sq_reg [NL];
    logic signed [31:0] a_reg [NL];
    logic [16:0] th1_reg;
    // Stage 2: sum
    logic [65:0] l2_reg;
    logic signed [31:0] a2_reg [NL];
    logic [16:0] th2_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            a_reg[0] <= ax; a_reg[1] <= ay; a_reg[2] <= az;
            sq_reg[0] <= 64'(ax * ax);
            sq_reg[1] <= 64'(ay * ay);
            sq_reg[2] <= 64'(az * az);
            th1_reg <= thresh;
            l2_reg <= 66'(sq_reg[0]) + 66'(sq_reg[1]) + 66'(sq_reg[2]);
            a2_reg <= a_reg;
            th2_reg <= th1_reg;
        end
    end

    // Square root: one result bit per stage (remainder/root restoring form)
    logic [65:0] rem_reg [NS+1];
    logic [65:0] val_reg [NS+1];
    logic [32:0] root_reg [NS+1];
    logic signed [31:0] as_reg [NS+1][NL];
    logic [16:0] ths_reg [NS+1];
    logic zero_reg [NS+1];

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0] <= '0;
            root_reg[0] <= '0;
            val_reg[0] <= l2_reg;
            as_reg[0] <= a2_reg;
            ths_reg[0] <= th2_reg;
            zero_reg[0] <= (l2_reg <= aapr_pkg::LenSqZeroLimit);
        end
    end

    // The sum of three squares stays below 2^64, so bit pairs start at bit 63
    for (genvar i = 0; i < NS; i++) begin : g_sqrt
        logic [67:0] rem_sh;
        logic [67:0] trial;
        assign rem_sh = {rem_reg[i], val_reg[i][63-2*i -: 2]};
        assign trial  = {33'd0, root_reg[i], 2'b01};
        always_ff @(posedge aclk) begin
            if (en) begin
                val_reg[i+1] <= val_reg[i];
                as_reg[i+1] <= as_reg[i];
                ths_reg[i+1] <= ths_reg[i];
                zero_reg[i+1] <= zero_reg[i];
                if (rem_sh >= trial) begin
                    rem_reg[i+1] <= 66'(rem_sh - trial);
                    root_reg[i+1] <= {root_reg[i][31:0], 1'b1};
                end else begin
                    rem_reg[i+1] <= 66'(rem_sh);
                    root_reg[i+1] <= {root_reg[i][31:0], 1'b0};
                end
            end
        end
    end

    // Length and replacement decision
    logic [32:0] len;
    logic        repl;
    assign len  = zero_reg[NS] ? 33'd0 : root_reg[NS];
    assign repl = (len == 33'd0) || (len < 33'(ths_reg[NS]));

    // Divider lanes: (|a| << 30) / len, one quotient bit per stage
    logic [32:0] dv_reg [ND+1];
    logic        rp_reg [ND+1];

    always_ff @(posedge aclk) begin
        if (en) begin
            dv_reg[0] <= (len == 33'd0) ? 33'd1 : len;
            rp_reg[0] <= repl;
        end
    end

    for (genvar d = 0; d < ND; d++) begin : g_dctl
        always_ff @(posedge aclk) begin
            if (en) begin
                dv_reg[d+1] <= dv_reg[d];
                rp_reg[d+1] <= rp_reg[d];
            end
        end
    end

    aapr_pkg::q30_t res [NL];

    for (genvar l = 0; l < NL; l++) begin : g_lane
        logic [61:0] num_reg [ND+1];
        logic [32:0] pr_reg [ND+1];
        logic [31:0] q_reg [ND+1];
        logic        sg_reg [ND+1];
        logic [31:0] mag;
        assign mag = as_reg[NS][l][31] ? 32'(-as_reg[NS][l]) : as_reg[NS][l];
        // Start from the numerator bits above bit 31 as the remainder: |a| <= len
        // keeps those quotient bits zero, so the low 32 numerator bits remain
        always_ff @(posedge aclk) begin
            if (en) begin
                num_reg[0] <= {mag, 30'd0};
                pr_reg[0] <= 33'(mag >> 2);
                q_reg[0] <= '0;
                sg_reg[0] <= as_reg[NS][l][31];
            end
        end
        for (genvar d = 0; d < ND; d++) begin : g_div
            logic [33:0] sh;
            assign sh = {pr_reg[d], num_reg[d][31-d]};
            always_ff @(posedge aclk) begin
                if (en) begin
                    num_reg[d+1] <= num_reg[d];
                    sg_reg[d+1] <= sg_reg[d];
                    if (sh >= 34'(dv_reg[d])) begin
                        pr_reg[d+1] <= 33'(sh - 34'(dv_reg[d]));
                        q_reg[d+1] <= {q_reg[d][30:0], 1'b1};
                    end else begin
                        pr_reg[d+1] <= 33'(sh);
                        q_reg[d+1] <= {q_reg[d][30:0], 1'b0};
                    end
                end
            end
        end
        // Reapply the sign of the axis component
        assign res[l] = sg_reg[ND] ? -aapr_pkg::q30_t'({1'b0, q_reg[ND]})
                                   :  aapr_pkg::q30_t'({1'b0, q_reg[ND]});
    end

    // Select unit X for a degenerate axis
    assign rx = rp_reg[ND] ? aapr_pkg::Q30One : res[0];
    assign ry = rp_reg[ND] ? '0 : res[1];
    assign rz = rp_reg[ND] ? '0 : res[2];
    assign replaced = rp_reg[ND];
endmodule

// File: hdl/aapr_rotate.sv
// Rodrigues matrix build and matrix-vector product, one row lane per result axis.
module aapr_rotate (
    input  logic               aclk,
    input  logic               en,
    input  aapr_pkg::q30_t     rx,
    input  aapr_pkg::q30_t     ry,
    input  aapr_pkg::q30_t     rz,
    input  aapr_pkg::q30_t     s,
    input  aapr_pkg::q30_t     c,
    input  logic signed [31:0] px,
    input  logic signed [31:0] py,
    input  logic signed [31:0] pz,
    output logic signed [31:0] qx,
    output logic signed [31:0] qy,
    output logic signed [31:0] qz,
    output logic               sat
);
    localparam int NL = aapr_pkg::NumLanes;

    // Stage A: t*r_i and s*r_i
    aapr_pkg::q30_t tr_reg [NL], sr_reg [NL], r_reg [NL], c_reg;
    logic signed [31:0] p_reg [NL];
    // Stage B: matrix
    aapr_pkg::q30_t m_reg [NL][NL];
    logic signed [31:0] pb_reg [NL];
    // Stage C: products
    logic signed [66:0] pr_reg [NL][NL];
    // Stage D: clamp
    logic signed [31:0] q_reg [NL];
    logic sat_reg [NL];

    aapr_pkg::q30_t rin [NL];
    assign rin[0] = rx; assign rin[1] = ry; assign rin[2] = rz;

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < NL; i++) begin
                tr_reg[i] <= aapr_pkg::mul30(aapr_pkg::Q30One - c, rin[i]);
                sr_reg[i] <= aapr_pkg::mul30(rin[i], s);
                r_reg[i] <= rin[i];
            end
            c_reg <= c;
            p_reg[0] <= px; p_reg[1] <= py; p_reg[2] <= pz;
        end
    end

    // Cross-product term for each matrix entry
    function automatic aapr_pkg::q30_t skew(input int i, input int j,
                                             input aapr_pkg::q30_t sr [NL]);
        aapr_pkg::q30_t v;
        v = '0;
        if (i == 0 && j == 1) v = -sr[2];
        if (i == 1 && j == 0) v =  sr[2];
        if (i == 0 && j == 2) v =  sr[1];
        if (i == 2 && j == 0) v = -sr[1];
        if (i == 1 && j == 2) v = -sr[0];
        if (i == 2 && j == 1) v =  sr[0];
        return v;
    endfunction

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < NL; i++) begin
                for (int j = 0; j < NL; j++) begin
                    m_reg[i][j] <= aapr_pkg::mul30(tr_reg[i], r_reg[j])
                        + ((i == j) ? c_reg : '0) + skew(i, j, sr_reg);
                end
            end
            pb_reg <= p_reg;
        end
    end

    // Row lanes: Q4.28 entry times point
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < NL; i++) begin
                for (int j = 0; j < NL; j++) begin
                    pr_reg[i][j] <= 67'((m_reg[i][j] + 35'sd2) >>> 2) * 67'(pb_reg[j]);
                end
            end
        end
    end

    // Sum, round and clamp each row
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < NL; i++) begin
                logic signed [68:0] acc;
                logic signed [68:0] q;
                acc = 69'(pr_reg[i][0]) + 69'(pr_reg[i][1]) + 69'(pr_reg[i][2])
                    + 69'sd134217728;
                q = acc >>> 28;
                if (q > 69'sd2147483647) begin
                    q_reg[i] <= 32'sh7FFFFFFF; sat_reg[i] <= 1'b1;
                end else if (q < -69'sd2147483648) begin
                    q_reg[i] <= 32'sh80000000; sat_reg[i] <= 1'b1;
                end else begin
                    q_reg[i] <= 32'(q); sat_reg[i] <= 1'b0;
                end
            end
        end
    end

    assign qx = q_reg[0];
    assign qy = q_reg[1];
    assign qz = q_reg[2];
    assign sat = sat_reg[0] | sat_reg[1] | sat_reg[2];
endmodule
